// ===== sv/motor_stall_power_limiter_defines.svh =====
// assertion macros used by the checker file msl_checker.sv
`ifndef MOTOR_STALL_POWER_LIMITER_DEFINES_SVH
`define MOTOR_STALL_POWER_LIMITER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MSL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MSL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/msl_pkg.sv =====
`default_nettype none
package msl_pkg;

  // default number of supervised channels
  localparam int MOTOR_COUNT_DEF = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_DEAD_ZONE  = 2'd0;
  localparam logic [1:0] CFG_SIG_TICKS  = 2'd1;
  localparam logic [1:0] CFG_PARTIAL_MS = 2'd2;
  localparam logic [1:0] CFG_FULL_MS    = 2'd3;

  // register reset values
  localparam logic [7:0]  DEAD_ZONE_RST  = 8'd15;
  localparam logic [15:0] SIG_TICKS_RST  = 16'd100;
  localparam logic [15:0] PARTIAL_MS_RST = 16'd250;
  localparam logic [15:0] FULL_MS_RST    = 16'd1000;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    LVL_NONE    = 2'd0,
    LVL_PARTIAL = 2'd1,
    LVL_FULL    = 2'd2
  } level_t;

  typedef struct packed {
    logic [7:0]  dead_zone;
    logic [15:0] sig_ticks;
    logic [15:0] partial_ms;
    logic [15:0] full_ms;
  } cfg_t;

  // one channel's record
  typedef struct packed {
    dir_t        dir;
    logic [31:0] move_time;
    logic [31:0] move_enc;
  } entry_t;

  // evaluation result handed back to the pipeline
  typedef struct packed {
    logic        wr_en;
    entry_t      wr_entry;
    logic [8:0]  power;
    level_t      level;
  } eval_t;

endpackage
`default_nettype wire

// ===== sv/msl_state_ram.sv =====
`default_nettype none
module msl_state_ram #(
  parameter int DEPTH = msl_pkg::MOTOR_COUNT_DEF,
  parameter int AW    = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [AW-1:0]     rd_addr,
  output msl_pkg::entry_t        rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire msl_pkg::entry_t   wr_data
);

  msl_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  msl_pkg::entry_t  rdata_r;
  logic [AW-1:0]    rd_addr_r;
  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  msl_pkg::entry_t  fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (vld_r[rd_addr]) begin
      rdata_r <= mem[rd_addr];
    end else begin
      rdata_r <= '0;
    end
    rd_addr_r <= rd_addr;
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      fwd_v_r <= 1'b0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
      fwd_v_r        <= 1'b1;
    end
  end

  // last write wins over a read that raced it
  assign rd_data = (fwd_v_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : rdata_r;

endmodule
`default_nettype wire

// ===== sv/msl_stall_eval.sv =====
`default_nettype none
module msl_stall_eval (
  input  wire msl_pkg::cfg_t     cfg,
  input  wire msl_pkg::entry_t   ent,
  input  wire logic [8:0]        power,
  input  wire logic [31:0]       now_ms,
  input  wire logic [31:0]       enc,
  output msl_pkg::eval_t         res
);

  logic [8:0]      mag;
  logic            stopped;
  msl_pkg::dir_t   dir_new;
  logic            restart;
  logic [32:0]     enc_gap;
  logic [32:0]     gap_abs;
  logic            moved;
  logic [31:0]     elapsed;
  logic            over_full;
  logic            over_part;
  logic [8:0]      rnd;
  logic [8:0]      half;

  always_comb begin
    mag       = power[8] ? 9'(-power) : power;
    stopped   = mag < {1'b0, cfg.dead_zone};
    dir_new   = stopped ? msl_pkg::DIR_STOP : (power[8] ? msl_pkg::DIR_REV : msl_pkg::DIR_FWD);
    restart   = stopped || (ent.dir != dir_new);
    enc_gap   = {ent.move_enc[31], ent.move_enc} - {enc[31], enc};
    gap_abs   = enc_gap[32] ? 33'(-enc_gap) : enc_gap;
    moved     = gap_abs > {17'b0, cfg.sig_ticks};
    elapsed   = now_ms - ent.move_time;
    // negative elapsed never exceeds a limit
    over_full = !elapsed[31] && (elapsed[30:0] > {15'b0, cfg.full_ms});
    over_part = !elapsed[31] && (elapsed[30:0] > {15'b0, cfg.partial_ms});
    // halve, truncating toward zero
    rnd       = power + {8'b0, power[8]};
    half      = {rnd[8], rnd[8:1]};

    res.wr_en             = restart || moved;
    res.wr_entry.dir      = dir_new;
    res.wr_entry.move_time = now_ms;
    res.wr_entry.move_enc = enc;
    if (restart || moved) begin
      res.power = power;
      res.level = msl_pkg::LVL_NONE;
    end else if (over_full) begin
      res.power = '0;
      res.level = msl_pkg::LVL_FULL;
    end else if (over_part) begin
      res.power = half;
      res.level = msl_pkg::LVL_PARTIAL;
    end else begin
      res.power = power;
      res.level = msl_pkg::LVL_NONE;
    end
  end

endmodule
`default_nettype wire

// ===== sv/motor_stall_power_limiter.sv =====
// channel  | handshake         | payload
// in       | in_valid/in_ready | in_motor_index, in_wanted_power, in_now_ms, in_encoder_count
// out      | out_valid/out_ready | out_allowed_power, out_stall_level
// cfg      | cfg_we (no wait)  | cfg_index, cfg_wdata
//
// one request per cycle sustained while results are accepted; a taken request is
// registered into the evaluate stage, then its result into the output register
// the per-channel record sits in a registered-read memory; a write in the evaluate stage
// is forwarded to a read issued at the same edge, so back-to-back requests to one
// channel see fresh state
// reset is synchronous; records read as zero until first written, no clearing pass
// a held result stalls the evaluate stage, and in_ready drops only when both are full
// requests naming an unknown channel are taken and dropped with no result
`default_nettype none
module motor_stall_power_limiter #(
  parameter int MOTOR_COUNT = msl_pkg::MOTOR_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_motor_index,
  input  wire logic signed [8:0]  in_wanted_power,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic signed [31:0] in_encoder_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [8:0]       out_allowed_power,
  output logic [1:0]              out_stall_level,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // configuration registers
  msl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone  <= msl_pkg::DEAD_ZONE_RST;
      cfg_r.sig_ticks  <= msl_pkg::SIG_TICKS_RST;
      cfg_r.partial_ms <= msl_pkg::PARTIAL_MS_RST;
      cfg_r.full_ms    <= msl_pkg::FULL_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        msl_pkg::CFG_DEAD_ZONE:  cfg_r.dead_zone  <= cfg_wdata[7:0];
        msl_pkg::CFG_SIG_TICKS:  cfg_r.sig_ticks  <= cfg_wdata;
        msl_pkg::CFG_PARTIAL_MS: cfg_r.partial_ms <= cfg_wdata;
        msl_pkg::CFG_FULL_MS:    cfg_r.full_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // evaluate stage registers
  logic            s1_v_r;
  logic [AW-1:0]   s1_addr_r;
  logic [8:0]      s1_power_r;
  logic [31:0]     s1_now_r;
  logic [31:0]     s1_enc_r;

  // output register
  logic            out_v_r;
  logic [8:0]      out_power_r;
  msl_pkg::level_t out_level_r;

  logic            advance;
  logic            in_take;
  logic [6:0]      idx_ext;
  logic            idx_known;
  logic [AW-1:0]   rd_addr;
  msl_pkg::entry_t rd_ent;
  msl_pkg::eval_t  ev;
  logic            wr_en;

  // the evaluate stage moves on when empty or the output slot frees up
  assign advance   = !s1_v_r || !out_v_r || out_ready;
  assign in_ready  = advance;
  assign in_take   = in_valid && advance;
  assign idx_ext   = {5'b0, in_motor_index};
  assign idx_known = idx_ext < 7'(MOTOR_COUNT);
  // while held, keep re-reading the held channel
  assign rd_addr   = advance ? idx_ext[AW-1:0] : s1_addr_r;
  assign wr_en     = s1_v_r && advance && ev.wr_en;

  msl_state_ram #(
    .DEPTH (MOTOR_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_ent),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (ev.wr_entry)
  );

  msl_stall_eval u_eval (
    .cfg    (cfg_r),
    .ent    (rd_ent),
    .power  (s1_power_r),
    .now_ms (s1_now_r),
    .enc    (s1_enc_r),
    .res    (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_v_r <= in_take && idx_known;
      end
      if (s1_v_r && advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_addr_r  <= idx_ext[AW-1:0];
      s1_power_r <= in_wanted_power;
      s1_now_r   <= in_now_ms;
      s1_enc_r   <= in_encoder_count;
    end
    if (s1_v_r && advance) begin
      out_power_r <= ev.power;
      out_level_r <= ev.level;
    end
  end

  assign out_valid         = out_v_r;
  assign out_allowed_power = out_power_r;
  assign out_stall_level   = out_level_r;

endmodule
`default_nettype wire

// ===== sv/msl_checker.sv =====
`default_nettype none
`include "motor_stall_power_limiter_defines.svh"
module msl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [8:0] out_allowed_power,
  input wire logic [1:0]        out_stall_level
);

  // a held result keeps its payload
  `MSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_allowed_power) && $stable(out_stall_level), "result changed while stalled")

  // a full stall always cuts the power
  `MSL_ASSERT_NOW(a_full_cut, clk, rst_n, out_valid && (out_stall_level == msl_pkg::LVL_FULL), out_allowed_power == 9'sd0, "full stall with nonzero power")

  // halving never reaches the most negative code
  `MSL_ASSERT_NOW(a_half_range, clk, rst_n, out_valid && (out_stall_level == msl_pkg::LVL_PARTIAL), out_allowed_power != -9'sd256, "halved power out of range")

  // requests are refused only behind a stalled result
  `MSL_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input blocked without output stall")

endmodule

bind motor_stall_power_limiter msl_checker u_msl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_allowed_power (out_allowed_power),
  .out_stall_level   (out_stall_level)
);
`default_nettype wire

// ===== sim/stall_guard_checker.sv =====
`default_nettype none
module stall_guard_checker
  import msl_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_motor_index,
  input  wire logic signed [8:0]  in_wanted_power,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic signed [31:0] in_encoder_count,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [8:0]  out_allowed_power,
  input  wire logic [1:0]         out_stall_level,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [8:0] power;
    level_t            level;
  } grant_t;

  cfg_t        limits;
  dir_t        rec_dir  [MOTOR_COUNT];
  logic [31:0] rec_time [MOTOR_COUNT];
  logic [31:0] rec_enc  [MOTOR_COUNT];
  grant_t      grant_q  [$];
  int          errs;

  function automatic void predict_grant(input logic [1:0] idx, input logic signed [8:0] pwr,
                                        input logic [31:0] now, input logic [31:0] enc);
    int                 m;
    int                 mag;
    dir_t               dir;
    longint             travel;
    logic signed [31:0] elapsed;
    grant_t             g;
    if (idx >= MOTOR_COUNT) return;
    m = idx;
    mag = (pwr < 0) ? -int'(pwr) : int'(pwr);
    if (mag < int'(limits.dead_zone)) dir = DIR_STOP;
    else dir = (pwr < 0) ? DIR_REV : DIR_FWD;
    g.power = pwr;
    g.level = LVL_NONE;
    if (dir == DIR_STOP || rec_dir[m] != dir) begin
      rec_dir[m]  = dir;
      rec_time[m] = now;
      rec_enc[m]  = enc;
    end else begin
      // exact 33-bit encoder distance
      travel = longint'(signed'(rec_enc[m])) - longint'(signed'(enc));
      if (travel < 0) travel = -travel;
      if (travel > longint'(limits.sig_ticks)) begin
        rec_time[m] = now;
        rec_enc[m]  = enc;
      end else begin
        elapsed = now - rec_time[m];
        if (elapsed > $signed({16'd0, limits.full_ms})) begin
          g.power = '0;
          g.level = LVL_FULL;
        end else if (elapsed > $signed({16'd0, limits.partial_ms})) begin
          g.power = 9'(int'(pwr) / 2);
          g.level = LVL_PARTIAL;
        end
      end
    end
    grant_q.push_back(g);
  endfunction

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      limits.dead_zone  = DEAD_ZONE_RST;
      limits.sig_ticks  = SIG_TICKS_RST;
      limits.partial_ms = PARTIAL_MS_RST;
      limits.full_ms    = FULL_MS_RST;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        rec_dir[i]  = DIR_STOP;
        rec_time[i] = '0;
        rec_enc[i]  = '0;
      end
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEAD_ZONE:  limits.dead_zone  = cfg_wdata[7:0];
          CFG_SIG_TICKS:  limits.sig_ticks  = cfg_wdata;
          CFG_PARTIAL_MS: limits.partial_ms = cfg_wdata;
          CFG_FULL_MS:    limits.full_ms    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_grant(in_motor_index, in_wanted_power, in_now_ms, in_encoder_count);
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          if (errs < 10)
            $display("unexpected result: power %0d level %0d", out_allowed_power,
                     out_stall_level);
          errs++;
        end else begin
          g = grant_q.pop_front();
          if (out_allowed_power !== g.power || out_stall_level !== g.level) begin
            if (errs < 10)
              $display("mismatch: expected power %0d level %0d, got power %0d level %0d",
                       g.power, g.level, out_allowed_power, out_stall_level);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= grant_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msl_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_motor_index;
  logic signed [8:0]  in_wanted_power;
  logic [31:0]        in_now_ms;
  logic signed [31:0] in_encoder_count;
  logic               out_valid;
  logic               out_ready;
  logic signed [8:0]  out_allowed_power;
  logic [1:0]         out_stall_level;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;

  // idle percentages for each side, changed between phases
  int snd_idle;
  int rcv_idle;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_reqs;

  // mirror of the limits, used only to shape the stimulus
  int dz_now;
  int sig_now;
  int part_now;
  int full_now;

  // a simple model of the motors: shared timer, per-channel encoder and direction
  logic [31:0]        clock_ms;
  logic signed [31:0] enc_pos [3];
  int                 lean    [3];

  motor_stall_power_limiter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_motor_index    (in_motor_index),
    .in_wanted_power   (in_wanted_power),
    .in_now_ms         (in_now_ms),
    .in_encoder_count  (in_encoder_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_allowed_power (out_allowed_power),
    .out_stall_level   (out_stall_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  stall_guard_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_motor_index    (in_motor_index),
    .in_wanted_power   (in_wanted_power),
    .in_now_ms         (in_now_ms),
    .in_encoder_count  (in_encoder_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_allowed_power (out_allowed_power),
    .out_stall_level   (out_stall_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    int seen_holds;
    int hold_left;
    seen_holds = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen_holds) begin
        seen_holds = hold_reqs;
        hold_left  = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // offer one request, with random idle cycles ahead of it, and wait until taken
  task automatic send_request(input logic [1:0] idx, input logic signed [8:0] pwr,
                              input logic [31:0] now, input logic [31:0] enc);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_motor_index   <= idx;
    in_wanted_power  <= pwr;
    in_now_ms        <= now;
    in_encoder_count <= enc;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every granted power has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // room for a dropped unknown-channel request still in the pipe
    repeat (4) @(posedge clk);
  endtask

  // program all four limits while the block is idle
  task automatic set_limits(input int dz, input int sig, input int part, input int full);
    logic [15:0] vals [4];
    logic [1:0]  idxs [4];
    settle();
    // junk in the upper byte of the dead zone write must be dropped
    vals[0] = {8'($urandom), 8'(dz)};
    vals[1] = 16'(sig);
    vals[2] = 16'(part);
    vals[3] = 16'(full);
    idxs[0] = CFG_DEAD_ZONE;
    idxs[1] = CFG_SIG_TICKS;
    idxs[2] = CFG_PARTIAL_MS;
    idxs[3] = CFG_FULL_MS;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    dz_now   = dz;
    sig_now  = sig;
    part_now = part;
    full_now = full;
  endtask

  // mostly plausible motion on known channels, with some fully random requests
  task automatic run_traffic(input int n, input bit with_hold);
    int                 sent;
    int                 m;
    int                 mag;
    int                 horizon;
    int                 drift;
    int                 sg;
    logic signed [8:0]  pwr;
    logic [1:0]         idx;
    sent = 0;
    while (sent < n) begin
      if (with_hold && sent == n / 2) hold_reqs++;
      if ($urandom_range(99) < 80) begin
        m = $urandom_range(2);
        // an occasional reversal breaks the stall history
        if ($urandom_range(99) < 8) lean[m] = -lean[m];
        if ($urandom_range(99) < 6) mag = $urandom_range(dz_now);
        else mag = $urandom_range(256, dz_now);
        if (lean[m] > 0 && mag > 255) mag = 255;
        pwr = 9'(lean[m] * mag);
        // time advances in steps sized so the limits get crossed within a few requests
        horizon  = ((full_now > part_now) ? full_now : part_now) / 3 + 4;
        clock_ms = clock_ms + 32'($urandom_range(horizon));
        sg = sig_now;
        if ($urandom_range(99) < 15) begin
          drift = sg + 1 + $urandom_range(50);
          if ($urandom_range(1)) drift = -drift;
        end else begin
          drift = int'($urandom_range(sg)) - sg / 2;
        end
        enc_pos[m] = enc_pos[m] + drift;
        send_request(2'(m), pwr, clock_ms, enc_pos[m]);
        sent++;
      end else begin
        // noise, sometimes throwing the shared timer somewhere else, wraps included
        if ($urandom_range(99) < 20) clock_ms = $urandom;
        if ($urandom_range(99) < 10) clock_ms = 32'hFFFF_F000 + $urandom_range(4095);
        idx = 2'($urandom_range(3));
        send_request(idx, 9'($urandom), $urandom, $urandom);
        if (idx < 3) sent++;
      end
    end
  endtask

  initial begin
    int part;
    // everything known from time zero
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_motor_index   <= '0;
    in_wanted_power  <= '0;
    in_now_ms        <= '0;
    in_encoder_count <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    hold_reqs = 0;
    snd_idle  = 9;
    rcv_idle  = 45;
    dz_now    = 15;
    sig_now   = 100;
    part_now  = 250;
    full_now  = 1000;
    clock_ms  = '0;
    for (int i = 0; i < 3; i++) begin
      enc_pos[i] = '0;
      lean[i]    = 1;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset limits
    // start from stopped, then creep under the tick threshold
    send_request(2'd0, 9'sd255, 32'd0, 32'd0);
    send_request(2'd0, 9'sd200, 32'd100, 32'd10);
    // exactly at the partial limit is still fine
    send_request(2'd0, 9'sd201, 32'd250, 32'd10);
    // one past it halves, odd value truncates
    send_request(2'd0, 9'sd201, 32'd251, -32'sd90);
    // encoder exactly at the threshold is not a move; exactly at full limit halves
    send_request(2'd0, 9'sd255, 32'd1000, 32'd100);
    send_request(2'd0, 9'sd255, 32'd1001, 32'd100);
    // one tick over the threshold refreshes the record
    send_request(2'd0, 9'sd255, 32'd1002, 32'd101);
    // below dead zone counts as stopped
    send_request(2'd0, -9'sd7, 32'd1003, 32'd101);
    send_request(2'd0, 9'sd0, 32'd1004, 32'd101);
    // most negative power, timer wrap across zero
    send_request(2'd1, -9'sd256, 32'hFFFF_FF00, 32'h7FFF_FFFF);
    send_request(2'd1, -9'sd256, 32'h0000_0100, 32'h7FFF_FFFF);
    send_request(2'd1, -9'sd255, 32'h0000_0400, 32'h7FFF_FFFF);
    // magnitude equal to dead zone moves; elapsed of half the timer range reads negative
    send_request(2'd1, -9'sd15, 32'h7FFF_FF00, 32'h7FFF_FFFF);
    // elapsed still reads negative from the old record time, so the odd power passes unhalved
    send_request(2'd1, -9'sd17, 32'h7FFF_FF00 + 32'd300, 32'h7FFF_FFFF);
    // encoder extremes: distance needs the full 33 bits
    send_request(2'd2, 9'sd15, 32'd5, 32'h8000_0000);
    send_request(2'd2, 9'sd16, 32'd6, 32'h7FFF_FFFF);
    send_request(2'd2, 9'sd16, 32'd7, 32'h7FFF_FFFF);
    // unknown channel is dropped silently
    send_request(2'd3, 9'sd100, 32'd8, 32'd0);
    send_request(2'd2, 9'sd14, 32'd9, 32'd0);
    send_request(2'd2, -9'sd1, 32'd10, 32'd0);
    // reversal straight through without stopping
    send_request(2'd2, -9'sd255, 32'd11, 32'd0);
    send_request(2'd2, 9'sd255, 32'd12, 32'd0);
    send_request(2'd3, -9'sd256, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clock_ms = 32'd2000;

    // random phases, sender light and receiver heavy idling first
    run_traffic(200, 1'b0);
    set_limits(0, 0, 0, 0);
    run_traffic(200, 1'b1);
    set_limits(255, 65535, 65535, 65535);
    run_traffic(200, 1'b0);

    // roles swapped
    snd_idle = 45;
    rcv_idle = 9;
    part = $urandom_range(500, 50);
    set_limits($urandom_range(40, 1), $urandom_range(300), part,
               part + $urandom_range(1500));
    run_traffic(200, 1'b0);
    // partial limit above the full one: full is checked first
    set_limits(10, 60, 700, 200);
    run_traffic(200, 1'b0);

    // no idling at all, long hold-off fills the pipe
    snd_idle = 0;
    rcv_idle = 0;
    set_limits($urandom_range(255), $urandom_range(65535), $urandom_range(65535),
               $urandom_range(65535));
    run_traffic(200, 1'b1);
    set_limits(20, 50, 100, 300);
    run_traffic(200, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/msl_pkg.sv
sv/msl_state_ram.sv
sv/msl_stall_eval.sv
sv/motor_stall_power_limiter.sv
sv/msl_checker.sv
sim/stall_guard_checker.sv
sim/testbench.sv
